// File: design/rrma_pkg.sv
package rrma_pkg;

  localparam int MAX_TOPICS = 16;
  localparam int JOB_BITS   = 32;
  localparam int TOPIC_BITS = $clog2(MAX_TOPICS);
  localparam int CNT_BITS   = $clog2(MAX_TOPICS + 1);

  localparam logic REQ_POST = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_RDATA = 3'b100
  } rrma_state_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic post;
    logic scan;
    logic fill;
  } rrma_cmd_t;

  typedef struct packed {
    logic is_take;
    logic need_norm;
  } rrma_status_t;

endpackage

// File: design/rrma_ram.sv
module rrma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/rrma_ctrl.sv
module rrma_ctrl
  import rrma_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  rrma_status_t status,
  output rrma_cmd_t    cmd
);

  rrma_state_t state;
  rrma_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_take) begin
          if (status.need_norm) begin
            cmd.norm = 1'b1;
          end else begin
            cmd.scan   = 1'b1;
            state_next = ST_RDATA;
          end
        end else if (out_free) begin
          cmd.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          cmd.fill   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.post || cmd.fill) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/rrma_dp.sv
module rrma_dp
  import rrma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CNT_BITS-1:0]   cfg_data,
  input  logic                  req_type,
  input  logic [TOPIC_BITS-1:0] topic,
  input  logic [JOB_BITS-1:0]   job_handle,
  input  rrma_cmd_t             cmd,
  output rrma_status_t          status,
  output logic                  granted,
  output logic [TOPIC_BITS-1:0] granted_topic,
  output logic [JOB_BITS-1:0]   job_out,
  output logic                  replaced,
  output logic                  rejected
);

  logic [CNT_BITS-1:0]   active_topics;
  logic [MAX_TOPICS-1:0] pending;
  logic [TOPIC_BITS-1:0] scan_start;
  logic [TOPIC_BITS-1:0] scan_base;
  logic                  req_type_r;
  logic [TOPIC_BITS-1:0] topic_r;
  logic [JOB_BITS-1:0]   job_r;
  logic                  grant_hit;
  logic [TOPIC_BITS-1:0] grant_topic;

  logic [CNT_BITS-1:0]   n;
  logic                  reject;
  logic [MAX_TOPICS-1:0] low_mask;
  logic [MAX_TOPICS-1:0] start_mask;
  logic [MAX_TOPICS-1:0] p;
  logic [MAX_TOPICS-1:0] hi;
  logic                  hit;
  logic [TOPIC_BITS-1:0] pick;
  logic [CNT_BITS-1:0]   pick_inc;
  logic [TOPIC_BITS-1:0] start_next;
  logic [JOB_BITS-1:0]   rdata;

  function automatic logic [TOPIC_BITS-1:0] first_set(input logic [MAX_TOPICS-1:0] v);
    logic [TOPIC_BITS-1:0] idx;
    idx = '0;
    for (int i = MAX_TOPICS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = TOPIC_BITS'(i);
      end
    end
    return idx;
  endfunction

  assign n = (active_topics > CNT_BITS'(MAX_TOPICS)) ? CNT_BITS'(MAX_TOPICS) : active_topics;
  assign reject = (CNT_BITS'(topic_r) >= n);

  always_comb begin
    for (int i = 0; i < MAX_TOPICS; i++) begin
      low_mask[i]   = (CNT_BITS'(i) < n);
      start_mask[i] = (TOPIC_BITS'(i) >= scan_base);
    end
  end

  assign p          = pending & low_mask;
  assign hi         = p & start_mask;
  assign hit        = |p;
  assign pick       = (|hi) ? first_set(hi) : first_set(p);
  assign pick_inc   = CNT_BITS'(pick) + CNT_BITS'(1);
  assign start_next = (pick_inc == n) ? '0 : pick_inc[TOPIC_BITS-1:0];

  assign status.is_take   = (req_type_r == REQ_TAKE);
  assign status.need_norm = (n != '0) && (CNT_BITS'(scan_base) >= n);

  rrma_ram #(
    .WIDTH(JOB_BITS),
    .DEPTH(MAX_TOPICS)
  ) u_job_ram (
    .clk  (clk),
    .we   (cmd.post && !reject),
    .waddr(topic_r),
    .wdata(job_r),
    .raddr(cmd.scan ? pick : grant_topic),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_topics <= '0;
      pending       <= '0;
      scan_start    <= '0;
    end else begin
      if (cfg_we) begin
        active_topics <= cfg_data;
      end
      if (cmd.scan && hit) begin
        pending[pick] <= 1'b0;
        scan_start    <= start_next;
      end
      if (cmd.post && !reject) begin
        pending[topic_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= req_type;
      topic_r    <= topic;
      job_r      <= job_handle;
      scan_base  <= scan_start;
    end
    if (cmd.norm) begin
      scan_base <= scan_base - n[TOPIC_BITS-1:0];
    end
    if (cmd.scan) begin
      grant_hit   <= hit;
      grant_topic <= hit ? pick : '0;
    end
    if (cmd.post) begin
      granted       <= 1'b0;
      granted_topic <= '0;
      job_out       <= '0;
      replaced      <= !reject && pending[topic_r];
      rejected      <= reject;
    end
    if (cmd.fill) begin
      granted       <= grant_hit;
      granted_topic <= grant_topic;
      job_out       <= grant_hit ? rdata : '0;
      replaced      <= 1'b0;
      rejected      <= 1'b0;
    end
  end

endmodule

// File: design/round_robin_mailbox_arbiter_top.sv
// Round-robin mailbox arbiter: one single-slot job mailbox per topic, served
// fairly. A post (req_type 0) stores job_handle in the slot of its topic and
// reports replaced when a pending job was dropped, or rejected when topic is
// not below active_topics. A take (req_type 1) grants the first pending job
// found round-robin from a rotating pointer and moves the pointer just past
// the granted topic. Every transaction yields exactly one result. Items are
// handled one at a time: a post's result is registered from the execute
// state, and a take passes through a further state for the job store's
// registered read before its result is registered. A take whose pointer is
// not below active_topics first subtracts active_topics from the pointer,
// one subtraction per step, until it is back in range, and a result still
// waiting on the output holds the next one back. A new item is accepted
// while the previous result still waits on the output. active_topics is to be
// written through cfg_we/cfg_data only while the block is idle (not enforced).
module round_robin_mailbox_arbiter_top
  import rrma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CNT_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [TOPIC_BITS-1:0] topic,
  input  logic [JOB_BITS-1:0]   job_handle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  granted,
  output logic [TOPIC_BITS-1:0] granted_topic,
  output logic [JOB_BITS-1:0]   job_out,
  output logic                  replaced,
  output logic                  rejected
);

  rrma_cmd_t    cmd;
  rrma_status_t status;

  rrma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rrma_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .topic        (topic),
    .job_handle   (job_handle),
    .cmd          (cmd),
    .status       (status),
    .granted      (granted),
    .granted_topic(granted_topic),
    .job_out      (job_out),
    .replaced     (replaced),
    .rejected     (rejected)
  );

endmodule
